// ----- sv/bsc_pkg.sv -----
package bsc_pkg;

  localparam int ID_W   = 16;
  localparam int CRD_W  = 31;
  localparam int HALF_W = 30;
  localparam int PT_W   = 32;
  localparam int MAG_W  = 31;
  localparam int RAD_W  = 60;
  localparam int ROOT_W = 30;
  localparam int REM_W  = 32;
  localparam int Q_W    = 15;
  localparam int NRM_W  = 16;
  localparam int AXES   = 3;
  localparam logic [NRM_W-1:0] Q14_ONE = NRM_W'(16384);

  // sideband that rides along the root and divide cells
  typedef struct packed {
    logic [ID_W-1:0]              box_id;
    logic [ID_W-1:0]              sphere_id;
    logic [HALF_W-1:0]            radius;
    logic                         hit;
    logic [AXES-1:0][PT_W-1:0]    touch;
    logic [AXES-1:0][MAG_W-1:0]   dmag;
    logic [AXES-1:0]              dneg;
  } side_t;

  typedef struct packed {
    logic [AXES-1:0][ROOT_W-1:0]  rem;
    logic [AXES-1:0][Q_W-1:0]     numlo;
    logic [AXES-1:0][Q_W-1:0]     quot;
  } div_t;

endpackage

// ----- sv/box_sphere_contact.sv -----
// Box/sphere contact test, fully pipelined.
// Pipeline of 3 front stages, 30 square-root cells, 15 divide cells and an output register.
// Throughput: one word per cycle; busy is tied low, every cell takes a new word each cycle.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
// The receiver cannot stall: every result is shown for exactly one cycle.
module box_sphere_contact (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [bsc_pkg::ID_W-1:0]     in_box_id,
  input  logic [bsc_pkg::ID_W-1:0]     in_sphere_id,
  input  logic signed [bsc_pkg::CRD_W-1:0] in_box_cx,
  input  logic signed [bsc_pkg::CRD_W-1:0] in_box_cy,
  input  logic signed [bsc_pkg::CRD_W-1:0] in_box_cz,
  input  logic [bsc_pkg::HALF_W-1:0]   in_half_x,
  input  logic [bsc_pkg::HALF_W-1:0]   in_half_y,
  input  logic [bsc_pkg::HALF_W-1:0]   in_half_z,
  input  logic signed [bsc_pkg::CRD_W-1:0] in_ball_x,
  input  logic signed [bsc_pkg::CRD_W-1:0] in_ball_y,
  input  logic signed [bsc_pkg::CRD_W-1:0] in_ball_z,
  input  logic [bsc_pkg::HALF_W-1:0]   in_ball_radius,
  output logic                         out_strobe,
  output logic                         out_hit,
  output logic [bsc_pkg::ID_W-1:0]     out_first_id,
  output logic [bsc_pkg::ID_W-1:0]     out_second_id,
  output logic [bsc_pkg::HALF_W-1:0]   out_depth,
  output logic signed [bsc_pkg::NRM_W-1:0] out_norm_x,
  output logic signed [bsc_pkg::NRM_W-1:0] out_norm_y,
  output logic signed [bsc_pkg::NRM_W-1:0] out_norm_z,
  output logic signed [bsc_pkg::PT_W-1:0]  out_touch_x,
  output logic signed [bsc_pkg::PT_W-1:0]  out_touch_y,
  output logic signed [bsc_pkg::PT_W-1:0]  out_touch_z
);

  localparam int NSQ = bsc_pkg::ROOT_W;
  localparam int NDV = bsc_pkg::Q_W;
  localparam int SQW = 2 * bsc_pkg::MAG_W;

  // the pipeline never pushes back
  assign busy = 1'b0;

  // ---------------- stage A: clamp into the box, take offset magnitude
  logic [bsc_pkg::AXES-1:0][bsc_pkg::CRD_W-1:0]  c_in, p_in;
  logic [bsc_pkg::AXES-1:0][bsc_pkg::HALF_W-1:0] h_in;
  bsc_pkg::side_t a_nxt, a_r;
  logic           a_vld_r;
  logic signed [32:0] lo, hi, p33, t33, d33, dn33;

  assign c_in = {in_box_cz, in_box_cy, in_box_cx};
  assign p_in = {in_ball_z, in_ball_y, in_ball_x};
  assign h_in = {in_half_z, in_half_y, in_half_x};

  always_comb begin
    a_nxt           = '0;
    a_nxt.box_id    = in_box_id;
    a_nxt.sphere_id = in_sphere_id;
    a_nxt.radius    = in_ball_radius;
    lo = '0; hi = '0; p33 = '0; t33 = '0; d33 = '0; dn33 = '0;
    for (int a = 0; a < bsc_pkg::AXES; a++) begin
      lo  = $signed({{2{c_in[a][bsc_pkg::CRD_W-1]}}, c_in[a]}) - $signed({3'b000, h_in[a]});
      hi  = $signed({{2{c_in[a][bsc_pkg::CRD_W-1]}}, c_in[a]}) + $signed({3'b000, h_in[a]});
      p33 = $signed({{2{p_in[a][bsc_pkg::CRD_W-1]}}, p_in[a]});
      if (p33 < lo)      t33 = lo;
      else if (p33 > hi) t33 = hi;
      else               t33 = p33;
      d33  = p33 - t33;
      dn33 = -d33;
      a_nxt.touch[a] = t33[bsc_pkg::PT_W-1:0];
      a_nxt.dneg[a]  = d33[32];
      a_nxt.dmag[a]  = d33[32] ? dn33[bsc_pkg::MAG_W-1:0] : d33[bsc_pkg::MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else        a_vld_r <= start;
    a_r <= a_nxt;
  end

  // ---------------- stage B: squares of the offsets and of the radius
  logic [bsc_pkg::AXES-1:0][SQW-1:0] sq_r;
  logic [SQW-1:0]  r2_r;
  bsc_pkg::side_t  b_r;
  logic            b_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else        b_vld_r <= a_vld_r;
    b_r <= a_r;
    for (int a = 0; a < bsc_pkg::AXES; a++) begin
      sq_r[a] <= SQW'(a_r.dmag[a]) * SQW'(a_r.dmag[a]);
    end
    r2_r <= SQW'(a_r.radius) * SQW'(a_r.radius);
  end

  // ---------------- stage C: sum and hit compare
  logic [SQW+1:0]             dist2;
  bsc_pkg::side_t             c_nxt;
  bsc_pkg::side_t             c_r;
  logic                       c_vld_r;
  logic [bsc_pkg::RAD_W-1:0]  rad_r;

  assign dist2 = {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};

  always_comb begin
    c_nxt     = b_r;
    c_nxt.hit = (dist2 < {2'b00, r2_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else        c_vld_r <= b_vld_r;
    c_r     <= c_nxt;
    // a hit keeps dist2 below 2^60, so the low bits are the whole radicand
    rad_r   <= dist2[bsc_pkg::RAD_W-1:0];
  end

  // ---------------- square-root chain: one root bit per cell
  logic           sq_vld  [NSQ+1];
  bsc_pkg::side_t sq_side [NSQ+1];
  logic [bsc_pkg::RAD_W-1:0]  sq_rad  [NSQ+1];
  logic [bsc_pkg::REM_W-1:0]  sq_rem  [NSQ+1];
  logic [bsc_pkg::ROOT_W-1:0] sq_root [NSQ+1];

  assign sq_vld[0]  = c_vld_r;
  assign sq_side[0] = c_r;
  assign sq_rad[0]  = rad_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
    bsc_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .vld_in   (sq_vld[i]),
      .side_in  (sq_side[i]),
      .rad_in   (sq_rad[i]),
      .rem_in   (sq_rem[i]),
      .root_in  (sq_root[i]),
      .vld_out  (sq_vld[i+1]),
      .side_out (sq_side[i+1]),
      .rad_out  (sq_rad[i+1]),
      .rem_out  (sq_rem[i+1]),
      .root_out (sq_root[i+1])
    );
  end

  // ---------------- divide chain: offset * 2^14 / distance, one bit per cell
  logic           dv_vld  [NDV+1];
  bsc_pkg::side_t dv_side [NDV+1];
  logic [bsc_pkg::ROOT_W-1:0] dv_dist [NDV+1];
  bsc_pkg::div_t  dv_st   [NDV+1];
  bsc_pkg::div_t  dv_init;

  // seed the remainder with the high numerator bits; on a hit |d| <= dist
  always_comb begin
    dv_init = '0;
    for (int a = 0; a < bsc_pkg::AXES; a++) begin
      dv_init.rem[a]   = sq_side[NSQ].dmag[a][bsc_pkg::MAG_W-1:1];
      dv_init.numlo[a] = {sq_side[NSQ].dmag[a][0], {(bsc_pkg::Q_W-1){1'b0}}};
    end
  end

  assign dv_vld[0]  = sq_vld[NSQ];
  assign dv_side[0] = sq_side[NSQ];
  assign dv_dist[0] = sq_root[NSQ];
  assign dv_st[0]   = dv_init;

  for (genvar j = 0; j < NDV; j++) begin : g_div
    bsc_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .vld_in   (dv_vld[j]),
      .side_in  (dv_side[j]),
      .dist_in  (dv_dist[j]),
      .div_in   (dv_st[j]),
      .vld_out  (dv_vld[j+1]),
      .side_out (dv_side[j+1]),
      .dist_out (dv_dist[j+1]),
      .div_out  (dv_st[j+1])
    );
  end

  // ---------------- output register: sign, zero-distance normal, miss mask
  bsc_pkg::side_t fs;
  bsc_pkg::div_t  fd;
  logic [bsc_pkg::AXES-1:0][bsc_pkg::NRM_W-1:0] nrm;
  logic [bsc_pkg::NRM_W-1:0] qx;

  assign fs = dv_side[NDV];
  assign fd = dv_st[NDV];

  always_comb begin
    nrm = '0;
    qx  = '0;
    if (dv_dist[NDV] == '0) begin
      nrm[1] = bsc_pkg::Q14_ONE;
    end else begin
      for (int a = 0; a < bsc_pkg::AXES; a++) begin
        qx     = {1'b0, fd.quot[a]};
        nrm[a] = fs.dneg[a] ? bsc_pkg::NRM_W'(-qx) : qx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else        out_strobe <= dv_vld[NDV];
    out_hit <= fs.hit;
    if (fs.hit) begin
      out_first_id  <= fs.box_id;
      out_second_id <= fs.sphere_id;
      out_depth     <= fs.radius - dv_dist[NDV];
      out_norm_x    <= nrm[0];
      out_norm_y    <= nrm[1];
      out_norm_z    <= nrm[2];
      out_touch_x   <= fs.touch[0];
      out_touch_y   <= fs.touch[1];
      out_touch_z   <= fs.touch[2];
    end else begin
      // drop everything but the flag on a miss
      out_first_id  <= '0;
      out_second_id <= '0;
      out_depth     <= '0;
      out_norm_x    <= '0;
      out_norm_y    <= '0;
      out_norm_z    <= '0;
      out_touch_x   <= '0;
      out_touch_y   <= '0;
      out_touch_z   <= '0;
    end
  end

endmodule

// ----- sv/bsc_sqrt_cell.sv -----
module bsc_sqrt_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        vld_in,
  input  bsc_pkg::side_t              side_in,
  input  logic [bsc_pkg::RAD_W-1:0]   rad_in,
  input  logic [bsc_pkg::REM_W-1:0]   rem_in,
  input  logic [bsc_pkg::ROOT_W-1:0]  root_in,
  output logic                        vld_out,
  output bsc_pkg::side_t              side_out,
  output logic [bsc_pkg::RAD_W-1:0]   rad_out,
  output logic [bsc_pkg::REM_W-1:0]   rem_out,
  output logic [bsc_pkg::ROOT_W-1:0]  root_out
);

  logic [bsc_pkg::REM_W+1:0]  rem_sh;
  logic [bsc_pkg::REM_W+1:0]  trial;
  logic [bsc_pkg::REM_W-1:0]  rem_nxt;
  logic [bsc_pkg::ROOT_W-1:0] root_nxt;

  // one root bit: bring down two radicand bits, try subtracting 4*root+1
  always_comb begin
    rem_sh = {rem_in, rad_in[bsc_pkg::RAD_W-1 -: 2]};
    trial  = {2'b00, root_in, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = bsc_pkg::REM_W'(rem_sh - trial);
      root_nxt = {root_in[bsc_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = bsc_pkg::REM_W'(rem_sh);
      root_nxt = {root_in[bsc_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_out <= 1'b0;
    else        vld_out <= vld_in;
    side_out <= side_in;
    rad_out  <= {rad_in[bsc_pkg::RAD_W-3:0], 2'b00};
    rem_out  <= rem_nxt;
    root_out <= root_nxt;
  end

endmodule

// ----- sv/bsc_div_cell.sv -----
module bsc_div_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        vld_in,
  input  bsc_pkg::side_t              side_in,
  input  logic [bsc_pkg::ROOT_W-1:0]  dist_in,
  input  bsc_pkg::div_t               div_in,
  output logic                        vld_out,
  output bsc_pkg::side_t              side_out,
  output logic [bsc_pkg::ROOT_W-1:0]  dist_out,
  output bsc_pkg::div_t               div_out
);

  bsc_pkg::div_t          div_nxt;
  logic [bsc_pkg::ROOT_W:0] sh;

  // one quotient bit per axis
  always_comb begin
    div_nxt = div_in;
    sh      = '0;
    for (int a = 0; a < bsc_pkg::AXES; a++) begin
      sh = {div_in.rem[a], div_in.numlo[a][bsc_pkg::Q_W-1]};
      div_nxt.numlo[a] = {div_in.numlo[a][bsc_pkg::Q_W-2:0], 1'b0};
      if (sh >= {1'b0, dist_in}) begin
        div_nxt.rem[a]  = bsc_pkg::ROOT_W'(sh - {1'b0, dist_in});
        div_nxt.quot[a] = {div_in.quot[a][bsc_pkg::Q_W-2:0], 1'b1};
      end else begin
        div_nxt.rem[a]  = bsc_pkg::ROOT_W'(sh);
        div_nxt.quot[a] = {div_in.quot[a][bsc_pkg::Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_out <= 1'b0;
    else        vld_out <= vld_in;
    side_out <= side_in;
    dist_out <= dist_in;
    div_out  <= div_nxt;
  end

endmodule

// ----- dv/contact_checker.sv -----
`timescale 1ns / 100ps

module contact_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic [bsc_pkg::ID_W-1:0]            in_box_id,
  input  logic [bsc_pkg::ID_W-1:0]            in_sphere_id,
  input  logic signed [bsc_pkg::CRD_W-1:0]    in_box_cx,
  input  logic signed [bsc_pkg::CRD_W-1:0]    in_box_cy,
  input  logic signed [bsc_pkg::CRD_W-1:0]    in_box_cz,
  input  logic [bsc_pkg::HALF_W-1:0]          in_half_x,
  input  logic [bsc_pkg::HALF_W-1:0]          in_half_y,
  input  logic [bsc_pkg::HALF_W-1:0]          in_half_z,
  input  logic signed [bsc_pkg::CRD_W-1:0]    in_ball_x,
  input  logic signed [bsc_pkg::CRD_W-1:0]    in_ball_y,
  input  logic signed [bsc_pkg::CRD_W-1:0]    in_ball_z,
  input  logic [bsc_pkg::HALF_W-1:0]          in_ball_radius,
  input  logic                                out_strobe,
  input  logic                                out_hit,
  input  logic [bsc_pkg::ID_W-1:0]            out_first_id,
  input  logic [bsc_pkg::ID_W-1:0]            out_second_id,
  input  logic [bsc_pkg::HALF_W-1:0]          out_depth,
  input  logic signed [bsc_pkg::NRM_W-1:0]    out_norm_x,
  input  logic signed [bsc_pkg::NRM_W-1:0]    out_norm_y,
  input  logic signed [bsc_pkg::NRM_W-1:0]    out_norm_z,
  input  logic signed [bsc_pkg::PT_W-1:0]     out_touch_x,
  input  logic signed [bsc_pkg::PT_W-1:0]     out_touch_y,
  input  logic signed [bsc_pkg::PT_W-1:0]     out_touch_z,
  output int                                  fail_count,
  output int                                  pending
);
  import bsc_pkg::*;

  typedef struct packed {
    logic                         hit;
    logic [ID_W-1:0]              first_id;
    logic [ID_W-1:0]              second_id;
    logic [HALF_W-1:0]            depth;
    logic [AXES-1:0][NRM_W-1:0]   norm;
    logic [AXES-1:0][PT_W-1:0]    touch;
  } contact_t;

  contact_t contact_q[$];

  function automatic logic [63:0] root64(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bv;
    res = '0;
    bv  = 64'h4000_0000_0000_0000;
    while (bv > x) bv = bv >> 2;
    while (bv != 0) begin
      if (x >= res + bv) begin
        x   = x - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  function automatic contact_t contact_of(
      input logic [ID_W-1:0] bid, input logic [ID_W-1:0] sid,
      input longint c[3], input longint h[3], input longint p[3],
      input logic [HALF_W-1:0] rad);
    contact_t    e;
    longint      t[3];
    longint      d[3];
    longint      a;
    logic [63:0] dist2;
    logic [63:0] r2;
    logic [63:0] dist_val;
    longint      n;
    e     = '0;
    dist2 = '0;
    for (int i = 0; i < 3; i++) begin
      // clamp the ball center into the box
      t[i] = p[i];
      if (p[i] < c[i] - h[i]) t[i] = c[i] - h[i];
      else if (p[i] > c[i] + h[i]) t[i] = c[i] + h[i];
      d[i]  = p[i] - t[i];
      a     = (d[i] < 0) ? -d[i] : d[i];
      dist2 = dist2 + 64'(a) * 64'(a);
    end
    r2 = 64'(rad) * 64'(rad);
    if (dist2 >= r2) return e;
    dist_val    = root64(dist2);
    e.hit       = 1'b1;
    e.first_id  = bid;
    e.second_id = sid;
    e.depth     = HALF_W'(64'(rad) - dist_val);
    for (int i = 0; i < 3; i++) begin
      if (dist_val > 0) n = (d[i] * 16384) / longint'(dist_val);
      else n = (i == 1) ? 16384 : 0;
      e.norm[i]  = NRM_W'(n);
      e.touch[i] = PT_W'(t[i]);
    end
    return e;
  endfunction

  always @(posedge clk) begin
    contact_t got;
    contact_t want;
    longint   c[3];
    longint   h[3];
    longint   p[3];
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (start && !busy) begin
        c = '{longint'(in_box_cx), longint'(in_box_cy), longint'(in_box_cz)};
        h = '{longint'(in_half_x), longint'(in_half_y), longint'(in_half_z)};
        p = '{longint'(in_ball_x), longint'(in_ball_y), longint'(in_ball_z)};
        contact_q.push_back(contact_of(in_box_id, in_sphere_id, c, h, p, in_ball_radius));
      end
      if (out_strobe) begin
        got.hit       = out_hit;
        got.first_id  = out_first_id;
        got.second_id = out_second_id;
        got.depth     = out_depth;
        got.norm      = '{out_norm_z, out_norm_y, out_norm_x};
        got.touch     = '{out_touch_z, out_touch_y, out_touch_x};
        if (contact_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result word: %p", got);
        end else begin
          want = contact_q.pop_front();
          if (got.hit !== want.hit || got.first_id !== want.first_id ||
              got.second_id !== want.second_id || got.depth !== want.depth ||
              got.norm !== want.norm || got.touch !== want.touch) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
    end
    pending <= contact_q.size();
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import bsc_pkg::*;

  localparam int RANDOM_WORDS = 1800;
  localparam int PIPE_DEPTH   = 49;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [ID_W-1:0]          box_id, sphere_id;
  logic signed [CRD_W-1:0]  box_cx, box_cy, box_cz;
  logic [HALF_W-1:0]        half_x, half_y, half_z;
  logic signed [CRD_W-1:0]  ball_x, ball_y, ball_z;
  logic [HALF_W-1:0]        ball_radius;
  logic                     out_strobe, out_hit;
  logic [ID_W-1:0]          out_first_id, out_second_id;
  logic [HALF_W-1:0]        out_depth;
  logic signed [NRM_W-1:0]  out_norm_x, out_norm_y, out_norm_z;
  logic signed [PT_W-1:0]   out_touch_x, out_touch_y, out_touch_z;
  int                       fail_count;
  int                       pending;

  // one input word: box and ball of a body pair
  typedef struct {
    logic [ID_W-1:0]         bid;
    logic [ID_W-1:0]         sid;
    logic signed [CRD_W-1:0] c[3];
    logic [HALF_W-1:0]       h[3];
    logic signed [CRD_W-1:0] p[3];
    logic [HALF_W-1:0]       r;
  } pair_t;

  localparam logic signed [CRD_W-1:0] CRD_MAX = {1'b0, {(CRD_W-1){1'b1}}};
  localparam logic signed [CRD_W-1:0] CRD_MIN = {1'b1, {(CRD_W-1){1'b0}}};
  localparam logic [HALF_W-1:0]       HALF_MAX = '1;

  box_sphere_contact DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_box_id(box_id), .in_sphere_id(sphere_id),
    .in_box_cx(box_cx), .in_box_cy(box_cy), .in_box_cz(box_cz),
    .in_half_x(half_x), .in_half_y(half_y), .in_half_z(half_z),
    .in_ball_x(ball_x), .in_ball_y(ball_y), .in_ball_z(ball_z),
    .in_ball_radius(ball_radius),
    .out_strobe(out_strobe), .out_hit(out_hit),
    .out_first_id(out_first_id), .out_second_id(out_second_id),
    .out_depth(out_depth),
    .out_norm_x(out_norm_x), .out_norm_y(out_norm_y), .out_norm_z(out_norm_z),
    .out_touch_x(out_touch_x), .out_touch_y(out_touch_y), .out_touch_z(out_touch_z)
  );

  contact_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_box_id(box_id), .in_sphere_id(sphere_id),
    .in_box_cx(box_cx), .in_box_cy(box_cy), .in_box_cz(box_cz),
    .in_half_x(half_x), .in_half_y(half_y), .in_half_z(half_z),
    .in_ball_x(ball_x), .in_ball_y(ball_y), .in_ball_z(ball_z),
    .in_ball_radius(ball_radius),
    .out_strobe(out_strobe), .out_hit(out_hit),
    .out_first_id(out_first_id), .out_second_id(out_second_id),
    .out_depth(out_depth),
    .out_norm_x(out_norm_x), .out_norm_y(out_norm_y), .out_norm_z(out_norm_z),
    .out_touch_x(out_touch_x), .out_touch_y(out_touch_y), .out_touch_z(out_touch_z),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  // clip a coordinate into the legal Q15.16 range
  function automatic logic signed [CRD_W-1:0] to_coord(input longint v);
    if (v > longint'(CRD_MAX)) return CRD_MAX;
    if (v < longint'(CRD_MIN)) return CRD_MIN;
    return CRD_W'(v);
  endfunction

  // well-formed pair: ball placed near a modest box, often touching it
  function automatic pair_t near_pair();
    pair_t  w;
    longint span;
    w.bid = ID_W'($urandom);
    w.sid = ID_W'($urandom);
    for (int i = 0; i < 3; i++) begin
      w.c[i] = to_coord(longint'($signed($urandom_range(32'h7FFF_FFFF, 0) >> 1)) -
                        longint'(32'h2000_0000));
      w.h[i] = HALF_W'($urandom_range(1 << ($urandom_range(22, 0)), 0));
      span   = longint'(w.h[i]) + longint'($urandom_range(1 << 18, 0));
      w.p[i] = to_coord(longint'(w.c[i]) +
                        longint'($urandom_range(2 * span, 0)) - span);
    end
    w.r = HALF_W'($urandom_range(1 << ($urandom_range(21, 0)), 0));
    return w;
  endfunction

  // noise: every field over its full range
  function automatic pair_t wild_pair();
    pair_t w;
    w.bid = ID_W'($urandom);
    w.sid = ID_W'($urandom);
    for (int i = 0; i < 3; i++) begin
      w.c[i] = CRD_W'($urandom);
      w.h[i] = HALF_W'($urandom);
      w.p[i] = CRD_W'($urandom);
    end
    w.r = HALF_W'($urandom);
    return w;
  endfunction

  // ball placed off one face at exactly its radius: touching is a miss
  function automatic pair_t grazing_pair();
    pair_t w;
    int    ax;
    w  = near_pair();
    ax = $urandom_range(2, 0);
    for (int i = 0; i < 3; i++) w.p[i] = w.c[i];
    w.h[ax]  = HALF_W'($urandom_range(1 << 20, 0));
    w.r      = HALF_W'($urandom_range(1 << 20, 1));
    w.p[ax]  = to_coord(longint'(w.c[ax]) + longint'(w.h[ax]) + longint'(w.r));
    if (w.p[ax] == CRD_MAX) w.r = '0;
    return w;
  endfunction

  // present one word and hold it until the block takes it
  task automatic send_word(input pair_t w, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    box_id      <= w.bid;
    sphere_id   <= w.sid;
    box_cx      <= w.c[0];
    box_cy      <= w.c[1];
    box_cz      <= w.c[2];
    half_x      <= w.h[0];
    half_y      <= w.h[1];
    half_z      <= w.h[2];
    ball_x      <= w.p[0];
    ball_y      <= w.p[1];
    ball_z      <= w.p[2];
    ball_radius <= w.r;
    do @(posedge clk); while (busy);
  endtask

  function automatic pair_t flat_pair(input logic signed [CRD_W-1:0] c,
                                      input logic [HALF_W-1:0] h,
                                      input logic signed [CRD_W-1:0] p,
                                      input logic [HALF_W-1:0] r);
    pair_t w;
    w.bid = '1;
    w.sid = '0;
    for (int i = 0; i < 3; i++) begin
      w.c[i] = c;
      w.h[i] = h;
      w.p[i] = p;
    end
    w.r = r;
    return w;
  endfunction

  initial begin
    pair_t w;
    int    gap;
    int    pick;
    start       = 1'b0;
    box_id      = '0;
    sphere_id   = '0;
    box_cx      = '0;
    box_cy      = '0;
    box_cz      = '0;
    half_x      = '0;
    half_y      = '0;
    half_z      = '0;
    ball_x      = '0;
    ball_y      = '0;
    ball_z      = '0;
    ball_radius = '0;
    rst_n       = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: everything zero, zero radius is a miss even at zero distance
    send_word(flat_pair('0, '0, '0, '0), 0);
    // ball center at the box center: zero distance, up normal
    send_word(flat_pair('0, '0, '0, 30'd1), 0);
    send_word(flat_pair(CRD_MAX, HALF_MAX, CRD_MIN, HALF_MAX), 0);
    send_word(flat_pair(CRD_MIN, HALF_MAX, CRD_MAX, HALF_MAX), 0);
    // far corners, largest radius: distance beyond any radius
    send_word(flat_pair(CRD_MAX, '0, CRD_MIN, HALF_MAX), 0);
    send_word(flat_pair(CRD_MIN, '0, CRD_MAX, HALF_MAX), 0);
    // point box, ball offset by one unit on each axis
    send_word(flat_pair('0, '0, CRD_W'(1), 30'd2), 0);
    send_word(flat_pair('0, '0, -CRD_W'(1), 30'd2), 0);
    // ball off each face, hit and exact touch
    for (int ax = 0; ax < 3; ax++) begin
      w = flat_pair('0, 30'h10000, '0, 30'h8000);
      w.p[ax] = CRD_W'(32'h18000);
      send_word(w, 1);
      w.p[ax] = -CRD_W'(32'h14000);
      send_word(w, 0);
      w.p[ax] = CRD_W'(32'h18000);
      w.r = 30'h8000;
      w.p[ax] = CRD_W'(32'h10000 + 32'h8000);
      w.r = 30'h8000;
      w.p[ax] = CRD_W'(32'h18000);
      w.h[ax] = 30'h10000;
      w.r = 30'h8000;
      w.p[ax] = CRD_W'(32'h18000);
      send_word(w, 0);
    end
    send_word(grazing_pair(), 0);
    send_word(grazing_pair(), 2);

    // random: mostly near pairs, some grazing, some noise
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(99, 0);
      if (pick < 75) w = near_pair();
      else if (pick < 85) w = grazing_pair();
      else w = wild_pair();
      gap = 0;
      // no idling across one long stretch
      if (n < 600 || n >= 900) begin
        while ($urandom_range(99, 0) < 31) gap++;
      end
      // drain the pipe once mid-run
      if (n == 1000) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_word(w, gap);
    end
    start <= 1'b0;

    // drain, then let the pipe run empty
    while (pending != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/bsc_pkg.sv
sv/bsc_sqrt_cell.sv
sv/bsc_div_cell.sv
sv/box_sphere_contact.sv
dv/contact_checker.sv
dv/tb_top.sv
